>>> design/light_event_scheduler_table_top_macros.svh
// Assertion macros for the light event scheduler table.
// Included by modules that carry concurrent checks; depends on clk and rst in scope.
`ifndef LIGHT_EVENT_SCHEDULER_TABLE_TOP_MACROS_SVH
`define LIGHT_EVENT_SCHEDULER_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LEST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LEST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lest_pkg.sv
// Shared types and constants for the light event scheduler table.
// No dependencies; used by lest_match and light_event_scheduler_table_top.
package lest_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);

  localparam int LIGHT_W  = 8;
  localparam int CODE_W   = 4;
  localparam int MINUTE_W = 11;
  localparam int DAY_W    = 3;

  // Request kinds
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_SCHED = 1'b1;

  // Day codes beyond a single weekday
  localparam logic [CODE_W-1:0] DAY_EVERY    = 4'd7;
  localparam logic [CODE_W-1:0] DAY_WEEKDAYS = 4'd8;
  localparam logic [CODE_W-1:0] DAY_WEEKEND  = 4'd9;

  // Weekdays
  localparam logic [DAY_W-1:0] SUNDAY   = 3'd0;
  localparam logic [DAY_W-1:0] MONDAY   = 3'd1;
  localparam logic [DAY_W-1:0] FRIDAY   = 3'd5;
  localparam logic [DAY_W-1:0] SATURDAY = 3'd6;

  typedef struct packed {
    logic                turn_on;
    logic [MINUTE_W-1:0] minute;
    logic [CODE_W-1:0]   code;
    logic [LIGHT_W-1:0]  light;
  } entry_t;

  typedef struct packed {
    logic [MINUTE_W-1:0] minute;
    logic [DAY_W-1:0]    day;
  } tod_t;

endpackage

>>> design/light_event_scheduler_table_top.sv
// Top level of the light event scheduler table: event memory, fill count and scan sequencer.
// Depends on lest_pkg, lest_match and light_event_scheduler_table_top_macros.svh.
//
// A request is taken when start is high and busy is low. A schedule request (cmd = 1)
// stores the event in the next free table slot, or is dropped when all 64 slots hold
// events; busy stays low. A tick request (cmd = 0) scans the stored events in slot
// order through a single memory read port and one compare unit, one slot per cycle,
// and keeps busy high through the scan, drain and flush states (a tick on an empty
// table leaves busy low). Each matching event yields one command on out_light and
// out_on, shown for exactly one cycle with strobe high; the final command of a tick
// also has last high and shows in the first cycle after busy falls. A tick with no
// match yields nothing.
// The receiver cannot stall: every strobe cycle must be consumed. Slots are filled in
// order and never freed, so a fill count stands in for per-slot valid bits and the
// table needs no clearing pass after reset.
`include "light_event_scheduler_table_top_macros.svh"

module light_event_scheduler_table_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic [lest_pkg::LIGHT_W-1:0]  light_id,
  input  logic [lest_pkg::CODE_W-1:0]   day_code,
  input  logic [lest_pkg::MINUTE_W-1:0] event_minute,
  input  logic                          turn_on,
  input  logic [lest_pkg::MINUTE_W-1:0] now_minute,
  input  logic [lest_pkg::DAY_W-1:0]    today,
  output logic                          strobe,
  output logic [lest_pkg::LIGHT_W-1:0]  out_light,
  output logic                          out_on,
  output logic                          last
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state;

  // Event table; contents are meaningful only below the fill count.
  lest_pkg::entry_t mem [lest_pkg::NUM_ENTRIES];

  logic [lest_pkg::CNT_W-1:0] count;
  logic [lest_pkg::IDX_W-1:0] rd_idx;
  lest_pkg::entry_t           rdata;
  logic                       rd_vld;
  lest_pkg::tod_t             now_q;

  // Held match: emitted once the next match or the end of the scan is known.
  logic                       pend_vld;
  lest_pkg::entry_t           pend;

  logic             accept;
  logic             sched_wr;
  logic             scan_end;
  logic             hit;
  lest_pkg::entry_t new_entry;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign sched_wr = accept && (cmd == lest_pkg::CMD_SCHED)
                    && (count < lest_pkg::CNT_W'(lest_pkg::NUM_ENTRIES));
  assign scan_end = ((lest_pkg::CNT_W'(rd_idx) + lest_pkg::CNT_W'(1)) == count);

  always_comb begin
    new_entry.turn_on = turn_on;
    new_entry.minute  = event_minute;
    new_entry.code    = day_code;
    new_entry.light   = light_id;
  end

  // Write the next free slot; read one slot per scan cycle.
  always_ff @(posedge clk) begin
    if (sched_wr) begin
      mem[count[lest_pkg::IDX_W-1:0]] <= new_entry;
    end
    rdata <= mem[rd_idx];
  end

  lest_match u_match (
    .entry (rdata),
    .now   (now_q),
    .hit   (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_idx   <= '0;
      rd_vld   <= 1'b0;
      pend_vld <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      // Strobe on a match that releases the held one, or on the final flush.
      strobe <= (rd_vld && hit && pend_vld) || ((state == S_FLUSH) && pend_vld);
      rd_vld <= (state == S_SCAN);

      if (sched_wr) begin
        count <= count + lest_pkg::CNT_W'(1);
      end

      // Compare stage: release the held match, hold the new one.
      if (rd_vld && hit) begin
        if (pend_vld) begin
          out_light <= pend.light;
          out_on    <= pend.turn_on;
          last      <= 1'b0;
        end
        pend     <= rdata;
        pend_vld <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && (cmd == lest_pkg::CMD_TICK) && (count != '0)) begin
            state        <= S_SCAN;
            rd_idx       <= '0;
            pend_vld     <= 1'b0;
            now_q.minute <= now_minute;
            now_q.day    <= today;
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state <= S_DRAIN;
          end else begin
            rd_idx <= rd_idx + lest_pkg::IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_FLUSH;
        end
        S_FLUSH: begin
          // Drop out of the scan; the held match, if any, is the last command.
          if (pend_vld) begin
            out_light <= pend.light;
            out_on    <= pend.turn_on;
            last      <= 1'b1;
          end
          pend_vld <= 1'b0;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LEST_ASSERT_NEXT(a_last_ends_tick, strobe && last, !strobe, "command follows last flag")
  `LEST_ASSERT_NOW(a_count_bound, 1'b1, count <= lest_pkg::CNT_W'(lest_pkg::NUM_ENTRIES), "fill count overflow")
  `LEST_ASSERT_NEXT(a_sched_fills, sched_wr, count == $past(count) + lest_pkg::CNT_W'(1), "schedule did not advance fill count")
  `LEST_ASSERT_NOW(a_read_in_scan, rd_vld, (state == S_SCAN) || (state == S_DRAIN), "read data outside scan")

endmodule

>>> design/lest_match.sv
// Shared compare unit: tests one stored event against the current time of day.
// Depends on lest_pkg.
module lest_match (
  input  lest_pkg::entry_t entry,
  input  lest_pkg::tod_t   now,
  output logic             hit
);

  logic minute_eq;
  logic day_ok;

  assign minute_eq = (entry.minute == now.minute);

  always_comb begin
    priority if (entry.code == lest_pkg::DAY_EVERY) begin
      day_ok = 1'b1;
    end else if (entry.code < lest_pkg::DAY_EVERY) begin
      day_ok = (entry.code[lest_pkg::DAY_W-1:0] == now.day);
    end else if (entry.code == lest_pkg::DAY_WEEKDAYS) begin
      day_ok = (now.day >= lest_pkg::MONDAY) && (now.day <= lest_pkg::FRIDAY);
    end else if (entry.code == lest_pkg::DAY_WEEKEND) begin
      day_ok = (now.day == lest_pkg::SUNDAY) || (now.day == lest_pkg::SATURDAY);
    end else begin
      // codes above weekend never fire
      day_ok = 1'b0;
    end
  end

  assign hit = minute_eq && day_ok;

endmodule
